[src/irpd_pkg.sv]
// shared types and constants for the infrared pulse-distance decoder
`default_nettype none

package irpd_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned TolW    = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEADER = 3'd1,
    PH_PREP   = 3'd2,
    PH_MARK   = 3'd3,
    PH_SPACE  = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEVEL_THRESHOLD   = 3'd0,
    REG_IDLE_LIMIT        = 3'd1,
    REG_LEADER_LENGTH     = 3'd2,
    REG_PREP_LENGTH       = 3'd3,
    REG_MARK_LENGTH       = 3'd4,
    REG_ONE_SPACE_MIN     = 3'd5,
    REG_ZERO_SPACE_LENGTH = 3'd6
  } cfg_reg_e;

  localparam logic [SampleW-1:0] RstLevelThreshold  = 10'd580;
  localparam logic [TimeW-1:0]   RstIdleLimit       = 16'd50000;
  localparam logic [TimeW-1:0]   RstLeaderLength    = 16'd5500;
  localparam logic [TimeW-1:0]   RstPrepLength      = 16'd1380;
  localparam logic [TimeW-1:0]   RstMarkLength      = 16'd415;
  localparam logic [TimeW-1:0]   RstOneSpaceMin     = 16'd910;
  localparam logic [TimeW-1:0]   RstZeroSpaceLength = 16'd430;

endpackage

`default_nettype wire

[src/ir_pulse_distance_decoder.sv]
// infrared pulse-distance frame decoder, top level
//
// Input channel: one beat per receiver sample (adc_sample_i, timer_now_i),
// valid/ready. Output channel: one beat per input beat carrying the decoder
// status after that sample (code, bit count, started/ended/ready flags).
// Config channel: cfg_index_i selects a register (threshold, idle limit,
// leader, preparation, mark, one-space minimum, zero-space centre);
// cfg_ready_o is always high. Writes are meant for when no beat is in flight.
// An accepted sample is held in an input register and its result beat is
// shown from the state registers. One beat per cycle while the receiver
// takes results; the sample-to-result path is a single pass of subtract,
// window compares and the phase update between input and state registers.
// The state registers double as the result register, so while the receiver
// stalls they hold; the input register still takes one more beat, after
// which in_ready_o drops until the result is taken.
// Reset (rst_ni low, asynchronous) returns the phase to idle, clears the
// code, count, flags and timing, and loads the register defaults.
`default_nettype none

module ir_pulse_distance_decoder #(
  parameter int unsigned LEADER_TOL = 500,
  parameter int unsigned PREP_TOL   = 100,
  parameter int unsigned MARK_TOL   = 30,
  parameter int unsigned SPACE_TOL  = 40
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [irpd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [irpd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [irpd_pkg::SampleW-1:0]    adc_sample_i,
  input  wire logic [irpd_pkg::TimeW-1:0]      timer_now_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [irpd_pkg::CodeW-1:0]           code_value_o,
  output logic [irpd_pkg::CountW-1:0]          bit_count_o,
  output logic                                 frame_started_o,
  output logic                                 frame_ended_o,
  output logic                                 frame_ready_o
);
  import irpd_pkg::*;

  localparam logic [TolW-1:0] LeaderTol = TolW'(LEADER_TOL);
  localparam logic [TolW-1:0] PrepTol   = TolW'(PREP_TOL);
  localparam logic [TolW-1:0] MarkTol   = TolW'(MARK_TOL);
  localparam logic [TolW-1:0] SpaceTol  = TolW'(SPACE_TOL);

  // strict window (centre - tol, centre + tol) without wrap
  function automatic logic in_window(logic [TimeW-1:0] t, logic [TimeW-1:0] centre,
                                     logic [TolW-1:0] tol);
    logic [TimeW:0] t_up;
    logic [TimeW:0] c_up;
    t_up = {1'b0, t} + {{(TimeW+1-TolW){1'b0}}, tol};
    c_up = {1'b0, centre} + {{(TimeW+1-TolW){1'b0}}, tol};
    return (t_up > {1'b0, centre}) && ({1'b0, t} < c_up);
  endfunction

  // configuration registers
  logic [SampleW-1:0] level_threshold_q;
  logic [TimeW-1:0]   idle_limit_q, leader_length_q, prep_length_q;
  logic [TimeW-1:0]   mark_length_q, one_space_min_q, zero_space_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_threshold_q   <= RstLevelThreshold;
      idle_limit_q        <= RstIdleLimit;
      leader_length_q     <= RstLeaderLength;
      prep_length_q       <= RstPrepLength;
      mark_length_q       <= RstMarkLength;
      one_space_min_q     <= RstOneSpaceMin;
      zero_space_length_q <= RstZeroSpaceLength;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LEVEL_THRESHOLD:   level_threshold_q   <= cfg_data_i[SampleW-1:0];
        REG_IDLE_LIMIT:        idle_limit_q        <= cfg_data_i;
        REG_LEADER_LENGTH:     leader_length_q     <= cfg_data_i;
        REG_PREP_LENGTH:       prep_length_q       <= cfg_data_i;
        REG_MARK_LENGTH:       mark_length_q       <= cfg_data_i;
        REG_ONE_SPACE_MIN:     one_space_min_q     <= cfg_data_i;
        REG_ZERO_SPACE_LENGTH: zero_space_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic               in_vld_q;
  logic [SampleW-1:0] sample_q;
  logic [TimeW-1:0]   now_q;
  logic               advance;

  assign advance    = in_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= adc_sample_i;
      now_q    <= timer_now_i;
    end
  end

  // decoder state, also the result register
  phase_e             phase_q, phase_d;
  logic               line_low_q;
  logic [TimeW-1:0]   last_edge_q;
  logic [CodeW-1:0]   code_q, code_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               started_q, started_d;
  logic               ended_q, ended_d;
  logic               ready_q, ready_d;
  logic               out_vld_q;

  logic [TimeW-1:0]   elapsed;
  logic               timeout;
  logic               now_low;
  logic               edge_seen;
  phase_e             phase_cur;
  phase_e             phase_eff;

  always_comb begin
    elapsed   = now_q - last_edge_q;
    timeout   = elapsed > idle_limit_q;
    now_low   = !(sample_q > level_threshold_q);
    edge_seen = now_low != line_low_q;
    unique case (phase_q)
      PH_LEADER, PH_PREP, PH_MARK, PH_SPACE: phase_cur = phase_q;
      default:                               phase_cur = PH_IDLE;
    endcase
    phase_eff = timeout ? PH_IDLE : phase_cur;
  end

  // next phase
  always_comb begin
    phase_d = phase_eff;
    if (edge_seen) begin
      unique case (phase_eff)
        PH_LEADER: begin
          if (!now_low && in_window(elapsed, leader_length_q, LeaderTol)) phase_d = PH_PREP;
        end
        PH_PREP: begin
          if (now_low && in_window(elapsed, prep_length_q, PrepTol)) phase_d = PH_MARK;
        end
        PH_MARK: begin
          if (!now_low && in_window(elapsed, mark_length_q, MarkTol)) phase_d = PH_SPACE;
        end
        PH_SPACE: begin
          if (now_low) begin
            if (elapsed > one_space_min_q ||
                in_window(elapsed, zero_space_length_q, SpaceTol)) begin
              phase_d = PH_MARK;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
        default: begin
          if (now_low) phase_d = PH_LEADER;
        end
      endcase
    end
  end

  // code, count and flags
  always_comb begin
    code_d    = code_q;
    count_d   = count_q;
    started_d = started_q;
    ended_d   = ended_q;
    ready_d   = ready_q;
    if (timeout && phase_cur == PH_MARK) begin
      ended_d = 1'b1;
      ready_d = 1'b1;
    end
    if (edge_seen) begin
      unique case (phase_eff)
        PH_SPACE: begin
          if (now_low) begin
            if (elapsed > one_space_min_q) begin
              code_d  = {code_q[CodeW-2:0], 1'b1};
              count_d = count_q + CountW'(1);
            end else if (in_window(elapsed, zero_space_length_q, SpaceTol)) begin
              code_d  = {code_q[CodeW-2:0], 1'b0};
              count_d = count_q + CountW'(1);
            end
          end
        end
        PH_LEADER, PH_PREP, PH_MARK: ;
        default: begin
          // falling edge from idle opens a new frame
          if (now_low) begin
            code_d    = '0;
            count_d   = '0;
            started_d = 1'b1;
            ended_d   = 1'b0;
            ready_d   = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      line_low_q  <= 1'b0;
      last_edge_q <= '0;
      code_q      <= '0;
      count_q     <= '0;
      started_q   <= 1'b0;
      ended_q     <= 1'b0;
      ready_q     <= 1'b0;
    end else if (advance) begin
      phase_q    <= phase_d;
      line_low_q <= now_low;
      if (edge_seen) last_edge_q <= now_q;
      code_q     <= code_d;
      count_q    <= count_d;
      started_q  <= started_d;
      ended_q    <= ended_d;
      ready_q    <= ready_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign code_value_o    = code_q;
  assign bit_count_o     = count_q;
  assign frame_started_o = started_q;
  assign frame_ended_o   = ended_q;
  assign frame_ready_o   = ready_q;

  // ended and ready are always set and cleared together
  a_ended_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_ended_o == frame_ready_o)
    else $error("frame_ended and frame_ready disagree");

  a_ready_from_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(frame_ready_o) |-> $past(phase_q) == PH_MARK)
    else $error("frame_ready rose outside a mark timeout");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(bit_count_o) |->
      (bit_count_o == $past(bit_count_o) + CountW'(1)) || (bit_count_o == '0))
    else $error("bit count moved by other than one step or clear");

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && in_vld_q))
    else $error("input stalled without an output stall");

endmodule

`default_nettype wire

[sim/tb_ir_pulse_distance_decoder.sv]
// testbench for the infrared pulse-distance decoder: predicted status beats checked per sample
`timescale 1ns / 100ps

module tb_ir_pulse_distance_decoder;
  import irpd_pkg::*;

  localparam int LeaderTol = 500;
  localparam int PrepTol   = 100;
  localparam int MarkTol   = 30;
  localparam int SpaceTol  = 40;
  localparam int ClkPeriod = 12;
  localparam int WatchdogCycles = 600000;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [CountW-1:0] count;
    logic              started;
    logic              ended;
    logic              ready;
  } ir_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SampleW-1:0]  adc_sample = '0;
  logic [TimeW-1:0]    timer_now = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CodeW-1:0]    code_value;
  logic [CountW-1:0]   bit_count;
  logic                frame_started;
  logic                frame_ended;
  logic                frame_ready;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  ir_pulse_distance_decoder #(
    .LEADER_TOL(LeaderTol),
    .PREP_TOL  (PrepTol),
    .MARK_TOL  (MarkTol),
    .SPACE_TOL (SpaceTol)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .adc_sample_i   (adc_sample),
    .timer_now_i    (timer_now),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .code_value_o   (code_value),
    .bit_count_o    (bit_count),
    .frame_started_o(frame_started),
    .frame_ended_o  (frame_ended),
    .frame_ready_o  (frame_ready)
  );

  // decoder mirror: registers and state
  logic [SampleW-1:0] thr_m;
  logic [TimeW-1:0]   idle_limit_m, leader_m, prep_m, mark_m, one_min_m, zero_m;
  phase_e             phase_m;
  logic               line_low_m;
  logic [TimeW-1:0]   last_edge_m;
  logic [CodeW-1:0]   code_m;
  logic [CountW-1:0]  count_m;
  logic               started_m, ended_m, ready_m;

  ir_status_t status_q[$];
  int failures = 0;
  int samples_sent = 0;
  int beats_checked = 0;
  int bits_decoded = 0;
  int timeouts_closed = 0;
  int settings_used = 1;

  // stimulus side: generator's view of time and line level
  logic [TimeW-1:0] stamp_gen = '0;
  bit low_gen = 1'b0;
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int hold_requests = 0;

  function automatic void reset_model();
    thr_m        = RstLevelThreshold;
    idle_limit_m = RstIdleLimit;
    leader_m     = RstLeaderLength;
    prep_m       = RstPrepLength;
    mark_m       = RstMarkLength;
    one_min_m    = RstOneSpaceMin;
    zero_m       = RstZeroSpaceLength;
    phase_m      = PH_IDLE;
    line_low_m   = 1'b0;
    last_edge_m  = '0;
    code_m       = '0;
    count_m      = '0;
    started_m    = 1'b0;
    ended_m      = 1'b0;
    ready_m      = 1'b0;
  endfunction

  function automatic void store_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (cfg_reg_e'(idx))
      REG_LEVEL_THRESHOLD:   thr_m = data[SampleW-1:0];
      REG_IDLE_LIMIT:        idle_limit_m = data;
      REG_LEADER_LENGTH:     leader_m = data;
      REG_PREP_LENGTH:       prep_m = data;
      REG_MARK_LENGTH:       mark_m = data;
      REG_ONE_SPACE_MIN:     one_min_m = data;
      REG_ZERO_SPACE_LENGTH: zero_m = data;
      default: ;
    endcase
  endfunction

  // open window, bounds taken without wrap
  function automatic bit in_window(logic [TimeW-1:0] t, logic [TimeW-1:0] centre, int tol);
    int lo;
    int hi;
    lo = int'(centre) - tol;
    hi = int'(centre) + tol;
    return (int'(t) > lo) && (int'(t) < hi);
  endfunction

  function automatic void predict_status(logic [SampleW-1:0] sample, logic [TimeW-1:0] stamp);
    logic [TimeW-1:0] elapsed;
    logic now_low;
    ir_status_t st;
    elapsed = stamp - last_edge_m;
    // timeout is judged before this sample's edge
    if (elapsed > idle_limit_m) begin
      if (phase_m == PH_MARK) begin
        ended_m = 1'b1;
        ready_m = 1'b1;
        timeouts_closed++;
      end
      phase_m = PH_IDLE;
    end
    now_low = !(sample > thr_m);
    if (now_low != line_low_m) begin
      last_edge_m = stamp;
      case (phase_m)
        PH_LEADER: if (!now_low && in_window(elapsed, leader_m, LeaderTol)) phase_m = PH_PREP;
        PH_PREP:   if (now_low && in_window(elapsed, prep_m, PrepTol)) phase_m = PH_MARK;
        PH_MARK:   if (!now_low && in_window(elapsed, mark_m, MarkTol)) phase_m = PH_SPACE;
        PH_SPACE: begin
          if (now_low) begin
            if (elapsed > one_min_m) begin
              code_m  = {code_m[CodeW-2:0], 1'b1};
              count_m = count_m + 8'd1;
              phase_m = PH_MARK;
              bits_decoded++;
            end else if (in_window(elapsed, zero_m, SpaceTol)) begin
              code_m  = {code_m[CodeW-2:0], 1'b0};
              count_m = count_m + 8'd1;
              phase_m = PH_MARK;
              bits_decoded++;
            end else begin
              phase_m = PH_IDLE;
            end
          end
        end
        default: begin
          if (now_low) begin
            phase_m   = PH_LEADER;
            ready_m   = 1'b0;
            started_m = 1'b1;
            ended_m   = 1'b0;
            code_m    = '0;
            count_m   = '0;
          end
        end
      endcase
    end
    line_low_m = now_low;
    st.code    = code_m;
    st.count   = count_m;
    st.started = started_m;
    st.ended   = ended_m;
    st.ready   = ready_m;
    status_q.push_back(st);
  endfunction

  function automatic void check_status();
    ir_status_t exp_st;
    if (status_q.size() == 0) begin
      $error("status beat with nothing expected: code_value %h", code_value);
      failures++;
      return;
    end
    exp_st = status_q.pop_front();
    beats_checked++;
    if (code_value !== exp_st.code) begin
      $error("code_value expected %h actual %h", exp_st.code, code_value);
      failures++;
    end
    if (bit_count !== exp_st.count) begin
      $error("bit_count expected %0d actual %0d", exp_st.count, bit_count);
      failures++;
    end
    if (frame_started !== exp_st.started) begin
      $error("frame_started expected %b actual %b", exp_st.started, frame_started);
      failures++;
    end
    if (frame_ended !== exp_st.ended) begin
      $error("frame_ended expected %b actual %b", exp_st.ended, frame_ended);
      failures++;
    end
    if (frame_ready !== exp_st.ready) begin
      $error("frame_ready expected %b actual %b", exp_st.ready, frame_ready);
      failures++;
    end
  endfunction

  // one process sees every beat on all three channels, prediction before check
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) store_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_status(adc_sample, timer_now);
      if (out_valid && out_ready) check_status();
    end
  end

  // receiver: segments of always-ready, random and sparse readiness, plus requested holds
  int hold_served = 0;
  int hold_left = 0;
  int seg_left = 0;
  int seg_mode = 0;

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= 64;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode <= $urandom_range(0, 2);
        seg_left <= $urandom_range(8, 60);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (seg_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] sample, input logic [TimeW-1:0] stamp);
    in_valid   <= 1'b1;
    adc_sample <= sample;
    timer_now  <= stamp;
    do @(posedge clk_i); while (!in_ready);
    samples_sent++;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end else if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  task automatic send_raw(input logic [SampleW-1:0] sample, input logic [TimeW-1:0] dt);
    stamp_gen = stamp_gen + dt;
    low_gen   = !(sample > thr_m);
    send_sample(sample, stamp_gen);
  endtask

  function automatic logic [SampleW-1:0] level_sample(input bit low);
    if (low) return 10'($urandom_range(0, thr_m));
    if (thr_m == 10'h3FF) return 10'h3FF;
    return 10'($urandom_range(thr_m + 1, 1023));
  endfunction

  // sometimes a sample at the old level falls inside the interval
  task automatic level_change(input bit low, input int dur);
    int part;
    if ($urandom_range(0, 3) == 0 && dur > 1) begin
      part = $urandom_range(1, dur - 1);
      send_raw(level_sample(low_gen), 16'(part));
      dur = dur - part;
    end
    send_raw(level_sample(low), 16'(dur));
  endtask

  function automatic int pick_len(input logic [TimeW-1:0] centre, input int tol, input bit bad);
    int lo;
    int hi;
    if (bad) return $urandom_range(0, 65535);
    lo = int'(centre) - tol + 1;
    hi = int'(centre) + tol - 1;
    if (lo < 0) lo = 0;
    if (hi > int'(idle_limit_m)) hi = int'(idle_limit_m);
    if (lo > hi) return lo > 65535 ? 65535 : lo;
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int pick_one(input bit bad);
    int lo;
    int hi;
    if (bad) return $urandom_range(0, 65535);
    lo = int'(one_min_m) + 1;
    hi = int'(idle_limit_m);
    if (lo > hi) return 65535;
    if (hi - lo > 3000 && $urandom_range(0, 7) != 0) hi = lo + 3000;
    return $urandom_range(lo, hi);
  endfunction

  task automatic send_frame(input int nbits, input bit broken, input bit close);
    int bad_step;
    bad_step = broken ? $urandom_range(0, 2 * nbits + 2) : -1;
    // get the line high, closing whatever came before when the limit allows
    if (low_gen)
      level_change(1'b0, (idle_limit_m != 16'hFFFF) ?
                   $urandom_range(idle_limit_m + 1, 65535) : $urandom_range(1, 3000));
    level_change(1'b1, $urandom_range(1, 3000));
    level_change(1'b0, pick_len(leader_m, LeaderTol, bad_step == 0));
    level_change(1'b1, pick_len(prep_m, PrepTol, bad_step == 1));
    for (int i = 0; i < nbits; i++) begin
      level_change(1'b0, pick_len(mark_m, MarkTol, bad_step == 2 * i + 2));
      level_change(1'b1, $urandom_range(0, 1) ? pick_one(bad_step == 2 * i + 3) :
                   pick_len(zero_m, SpaceTol, bad_step == 2 * i + 3));
    end
    if (close && idle_limit_m != 16'hFFFF)
      send_raw(10'($urandom_range(0, 1023)), 16'($urandom_range(idle_limit_m + 1, 65535)));
  endtask

  task automatic send_noise(input int n);
    repeat (n)
      send_raw(10'($urandom_range(0, 1023)),
               $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1500)));
  endtask

  task automatic run_random(input int n);
    int stop_at;
    int pick;
    stop_at = samples_sent + n;
    while (samples_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) send_noise($urandom_range(1, 6));
      else send_frame($urandom_range(0, 34), pick < 4, $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    // the beat accepted at this edge may not be queued yet
    @(posedge clk_i);
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic apply_config(input logic [CfgDataW-1:0] thr, idle, leader, prep, mark, one,
                              zero);
    settle();
    write_reg(REG_LEVEL_THRESHOLD, thr);
    write_reg(REG_IDLE_LIMIT, idle);
    write_reg(REG_LEADER_LENGTH, leader);
    write_reg(REG_PREP_LENGTH, prep);
    write_reg(REG_MARK_LENGTH, mark);
    write_reg(REG_ONE_SPACE_MIN, one);
    write_reg(REG_ZERO_SPACE_LENGTH, zero);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // hand-placed frame at reset settings: window bounds, wrong level, timeouts, bad space
  task automatic test_directed_frame();
    send_raw(10'd1023, 16'd0);
    send_raw(10'd0, 16'd65535);     // timeout from idle, falling edge opens the leader
    send_raw(10'd700, 16'd5000);    // leader at lower bound, rejected
    send_raw(10'd580, 16'd5501);    // threshold itself reads low, wrong level
    send_raw(10'd581, 16'd5999);
    send_raw(10'd12, 16'd1281);
    send_raw(10'd900, 16'd445);     // mark at upper bound, rejected
    send_raw(10'd100, 16'd415);
    send_raw(10'd1000, 16'd386);
    send_raw(10'd990, 16'd200);
    send_raw(10'd5, 16'd711);       // space just above the one minimum
    send_raw(10'd800, 16'd415);
    send_raw(10'd300, 16'd391);
    send_raw(10'd600, 16'd415);
    send_raw(10'd0, 16'd469);
    send_raw(10'd1023, 16'd50001);  // timeout in mark closes the frame
    send_raw(10'd0, 16'd100);
    send_raw(10'd1023, 16'd5500);
    send_raw(10'd0, 16'd1380);
    send_raw(10'd1023, 16'd415);
    send_raw(10'd0, 16'd470);       // space outside both windows
    send_raw(10'd1023, 16'd100);    // rising edge in idle
    send_raw(10'd0, 16'd50000);     // exactly the idle limit is no timeout
    send_raw(10'd0, 16'd50001);     // timeout outside mark leaves flags alone
  endtask

  task automatic test_reset_config_random();
    run_random(40);
  endtask

  task automatic test_short_timing();
    apply_config(16'hFC00 | 16'($urandom_range(200, 800)), 16'd4000, 16'd300, 16'd60, 16'd20,
                 16'd150, 16'd30);
    run_random(40);
  endtask

  task automatic test_receiver_hold();
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    send_frame(12, 1'b0, 1'b1);
    gaps_on = 1'b1;
  endtask

  task automatic test_bit_count_wrap();
    send_frame(260, 1'b0, 1'b1);
  endtask

  task automatic test_config_extremes();
    // widest timing, threshold masked down to zero
    apply_config(16'hFC00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    repeat (3) send_frame($urandom_range(1, 6), 1'b0, 1'b0);
    send_noise(4);
    apply_config(16'd512, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    repeat (3) send_frame($urandom_range(1, 6), 1'b0, 1'b0);
    send_noise(4);
    // line can never read high, and any nonzero elapsed time exceeds the zero idle limit
    apply_config(16'hA7FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    settle();
    write_reg(RegUnused, 16'hFFFF);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    send_noise(8);
    send_frame(3, 1'b0, 1'b1);
  endtask

  task automatic test_random_config();
    logic [TimeW-1:0] zero;
    repeat (3) begin
      zero = 16'($urandom_range(0, 1500));
      apply_config(16'($urandom), 16'($urandom_range(2000, 65535)),
                   16'($urandom_range(0, 20000)), 16'($urandom_range(0, 5000)),
                   16'($urandom_range(0, 2000)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : zero + 16'($urandom_range(0, 2000)),
                   zero);
      run_random(20);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frame();
    test_reset_config_random();
    test_short_timing();
    test_receiver_hold();
    test_bit_count_wrap();
    test_config_extremes();
    test_random_config();
    settle();
    repeat (4) @(posedge clk_i);
    if (status_q.size() != 0) begin
      $error("%0d status beats never arrived", status_q.size());
      failures++;
    end
    $display("run covered %0d samples and %0d status beats over %0d register settings",
             samples_sent, beats_checked, settings_used);
    $display("decoded %0d bits, %0d frames closed by idle timeout", bits_decoded,
             timeouts_closed);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(WatchdogCycles * ClkPeriod);
    $display("Regression FAIL");
    $finish;
  end

endmodule
